>>> rtl/i128alu_pkg.sv
// Package for the 128-bit ALU: command codes, controller states and the
// command/status structs shared by the controller and the datapath.
package i128alu_pkg;

  localparam int WORD_BITS = 128;
  localparam int HALF_BITS = WORD_BITS / 2;
  localparam int SHIFT_BITS = $clog2(WORD_BITS);
  localparam int COUNT_BITS = $clog2(WORD_BITS + 1);

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_AND = 4'd4,
    CMD_OR  = 4'd5,
    CMD_XOR = 4'd6,
    CMD_NOT = 4'd7,
    CMD_SHL = 4'd8,
    CMD_SAR = 4'd9,
    CMD_ROL = 4'd10,
    CMD_ROR = 4'd11,
    CMD_CMP = 4'd12
  } command_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture operands and do the logic-unit operations
    logic mul_step;  // one Booth iteration
    logic div_step;  // one restoring division iteration
    logic fix_sign;  // negate quotient if needed
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_mul;
    logic is_div;   // divide with nonzero divisor
    logic last;     // iteration counter on its final step
  } dp_status_t;

endpackage

>>> rtl/i128alu_if.sv
// Valid/ready channel interfaces for the 128-bit ALU requests and results.
// Depends on nothing but the widths written here.
interface i128alu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [63:0] a_hi;
  logic [63:0] a_lo;
  logic [63:0] b_hi;
  logic [63:0] b_lo;
  logic [6:0]  shift_amount;
  modport source(output valid, command, a_hi, a_lo, b_hi, b_lo, shift_amount, input ready);
  modport sink(input valid, command, a_hi, a_lo, b_hi, b_lo, shift_amount, output ready);
endinterface

interface i128alu_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  logic        less_than;
  logic        equal_flag;
  logic        divide_by_zero;
  modport source(output valid, result_hi, result_lo, less_than, equal_flag, divide_by_zero,
                 input ready);
  modport sink(input valid, result_hi, result_lo, less_than, equal_flag, divide_by_zero,
               output ready);
endinterface

>>> rtl/i128alu_ctrl.sv
// Controller state machine of the 128-bit ALU: sequences load, iterations,
// sign fix and result hand-off. Depends on i128alu_pkg.
module i128alu_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output i128alu_pkg::dp_cmd_t    cmd,
  input  i128alu_pkg::dp_status_t status
);

  i128alu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i128alu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      i128alu_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.is_mul) state_next = i128alu_pkg::ST_MUL;
          else if (status.is_div) state_next = i128alu_pkg::ST_DIV;
          else state_next = i128alu_pkg::ST_DONE;
        end
      end
      i128alu_pkg::ST_MUL: if (status.last) state_next = i128alu_pkg::ST_DONE;
      i128alu_pkg::ST_DIV: if (status.last) state_next = i128alu_pkg::ST_FIX;
      i128alu_pkg::ST_FIX: state_next = i128alu_pkg::ST_DONE;
      i128alu_pkg::ST_DONE: if (out_ready) state_next = i128alu_pkg::ST_IDLE;
      default: state_next = i128alu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == i128alu_pkg::ST_IDLE);
    out_valid = (state == i128alu_pkg::ST_DONE);
    cmd.load = in_ready && in_valid;
    cmd.mul_step = (state == i128alu_pkg::ST_MUL);
    cmd.div_step = (state == i128alu_pkg::ST_DIV);
    cmd.fix_sign = (state == i128alu_pkg::ST_FIX);
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != i128alu_pkg::ST_IDLE |-> !cmd.load) else $error("load while busy");
  a_fix_after_div: assert property (@(posedge clk) disable iff (rst)
    state == i128alu_pkg::ST_FIX |-> $past(state) == i128alu_pkg::ST_DIV)
    else $error("sign fix without divide");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

>>> rtl/i128alu_dp.sv
// Datapath of the 128-bit ALU: operand registers, combinational logic unit,
// Booth multiply and restoring divide iteration. Depends on i128alu_pkg.
module i128alu_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  i128alu_pkg::dp_cmd_t     cmd,
  output i128alu_pkg::dp_status_t  status,
  input  logic [3:0]               command,
  input  logic [i128alu_pkg::WORD_BITS-1:0] a_in,
  input  logic [i128alu_pkg::WORD_BITS-1:0] b_in,
  input  logic [6:0]               shift_amount,
  output logic [i128alu_pkg::WORD_BITS-1:0] result,
  output logic                     less_than,
  output logic                     equal_flag,
  output logic                     divide_by_zero
);

  localparam int W = i128alu_pkg::WORD_BITS;

  logic [W-1:0] acc;    // product or remainder
  logic [W-1:0] mcand;  // multiplicand or divisor magnitude
  logic [W-1:0] work;   // multiplier or dividend / quotient
  logic         booth_prev;
  logic         negate;
  logic [i128alu_pkg::COUNT_BITS-1:0] count;

  logic [W-1:0] a_neg, b_neg, quick;
  logic [i128alu_pkg::SHIFT_BITS-1:0] sh;
  logic [2*W-1:0] rot;
  logic [W:0] rem_sh, rem_diff;
  logic [W-1:0] booth_sum;

  assign a_neg = -a_in;
  assign b_neg = -b_in;
  assign sh = shift_amount[i128alu_pkg::SHIFT_BITS-1:0];
  assign rot = {a_in, a_in};

  always_comb begin
    quick = '0;
    case (command)
      i128alu_pkg::CMD_ADD: quick = a_in + b_in;
      i128alu_pkg::CMD_SUB: quick = a_in - b_in;
      i128alu_pkg::CMD_AND: quick = a_in & b_in;
      i128alu_pkg::CMD_OR:  quick = a_in | b_in;
      i128alu_pkg::CMD_XOR: quick = a_in ^ b_in;
      i128alu_pkg::CMD_NOT: quick = ~a_in;
      i128alu_pkg::CMD_SHL: quick = a_in << sh;
      i128alu_pkg::CMD_SAR: quick = W'($signed(a_in) >>> sh);
      i128alu_pkg::CMD_ROL: quick = rot[2*W-1-sh -: W];
      i128alu_pkg::CMD_ROR: quick = rot[sh +: W];
      default: quick = '0;
    endcase
  end

  // Booth radix-2: look at the current multiplier bit and the one before it.
  always_comb begin
    booth_sum = acc;
    if (work[0] && !booth_prev) booth_sum = acc - mcand;
    else if (!work[0] && booth_prev) booth_sum = acc + mcand;
  end

  assign rem_sh = {acc, work[W-1]};
  assign rem_diff = rem_sh - {1'b0, mcand};

  assign status.is_mul = (command == i128alu_pkg::CMD_MUL);
  assign status.is_div = (command == i128alu_pkg::CMD_DIV) && (b_in != '0);
  assign status.last = (count == i128alu_pkg::COUNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= i128alu_pkg::COUNT_BITS'(W);
    end else if (cmd.mul_step || cmd.div_step) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      less_than <= 1'b0;
      equal_flag <= 1'b0;
      divide_by_zero <= 1'b0;
    end else if (cmd.load) begin
      acc <= '0;
      booth_prev <= 1'b0;
      less_than <= 1'b0;
      equal_flag <= 1'b0;
      divide_by_zero <= 1'b0;
      negate <= a_in[W-1] ^ b_in[W-1];
      result <= quick;
      if (command == i128alu_pkg::CMD_DIV) begin
        mcand <= b_in[W-1] ? b_neg : b_in;
        work <= a_in[W-1] ? a_neg : a_in;
        divide_by_zero <= (b_in == '0);
      end else begin
        mcand <= a_in;
        work <= b_in;
      end
      if (command == i128alu_pkg::CMD_CMP) begin
        less_than <= $signed(a_in) < $signed(b_in);
        equal_flag <= (a_in == b_in);
      end
    end else if (cmd.mul_step) begin
      // Multiplicand shifts left instead of the product shifting right.
      acc <= booth_sum;
      booth_prev <= work[0];
      work <= work >> 1;
      mcand <= mcand << 1;
      if (status.last) result <= booth_sum;
    end else if (cmd.div_step) begin
      if (!rem_diff[W]) begin
        acc <= rem_diff[W-1:0];
        work <= {work[W-2:0], 1'b1};
      end else begin
        acc <= rem_sh[W-1:0];
        work <= {work[W-2:0], 1'b0};
      end
    end else if (cmd.fix_sign) begin
      result <= negate ? -work : work;
    end
  end

  a_count_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_step || cmd.div_step) |-> count != '0) else $error("iteration overrun");
  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load) && $past(command) != i128alu_pkg::CMD_DIV |-> !divide_by_zero)
    else $error("divide flag on other command");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(divide_by_zero && (less_than || equal_flag))) else $error("flags overlap");

endmodule

>>> rtl/int128_booth_mul_div_alu.sv
// Multicycle 128-bit ALU, one request in flight at a time. Add/sub/logic/shift/
// rotate/compare go from the accept cycle straight to the result state; multiply
// runs 128 Booth steps before the result, and divide by a nonzero divisor runs
// 128 restoring steps and a sign fix; divide by zero skips both. The result
// register holds until the receiver takes it.
// Depends on i128alu_pkg, i128alu_if, i128alu_ctrl and i128alu_dp.
module int128_booth_mul_div_alu (
  input logic          clk,
  input logic          rst,
  i128alu_req_if.sink  req,
  i128alu_rsp_if.source rsp
);

  i128alu_pkg::dp_cmd_t    cmd;
  i128alu_pkg::dp_status_t status;
  logic [i128alu_pkg::WORD_BITS-1:0] result;

  i128alu_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .status(status)
  );

  i128alu_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .command(req.command),
    .a_in({req.a_hi, req.a_lo}),
    .b_in({req.b_hi, req.b_lo}),
    .shift_amount(req.shift_amount),
    .result(result),
    .less_than(rsp.less_than),
    .equal_flag(rsp.equal_flag),
    .divide_by_zero(rsp.divide_by_zero)
  );

  assign rsp.result_hi = result[i128alu_pkg::WORD_BITS-1:i128alu_pkg::HALF_BITS];
  assign rsp.result_lo = result[i128alu_pkg::HALF_BITS-1:0];

endmodule
